### hw/rtl/cell_signal_quality_averager_assert.svh
// assertion macros included by the controller (csqa_ctrl)
`ifndef CELL_SIGNAL_QUALITY_AVERAGER_ASSERT_SVH
`define CELL_SIGNAL_QUALITY_AVERAGER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CSQA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define CSQA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/csqa_pkg.sv
// ----------------------------------------------------------------------------
// csqa_pkg
// shared types and constants of the signal quality averager
// ----------------------------------------------------------------------------
package csqa_pkg;

  localparam int unsigned MaxWindowDefault = 16;
  localparam int unsigned WinW = 5;
  localparam int unsigned AvgW = 15;
  localparam int unsigned CntW = 7;      // counts up to 127
  localparam int unsigned SumW = 24;     // 64 * 13400 fits
  localparam logic [7:0] CodeUnknown = 8'd255;
  localparam logic [WinW-1:0] WinReset = 5'd10;

  localparam logic [1:0] ModeLte = 2'd0;
  localparam logic [1:0] ModeWcdma = 2'd1;
  localparam logic [1:0] ModeGsm = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic store;      // write sample to ring, advance pointers
    logic clr_acc;    // clear sums and counts, load walk pointer
    logic rd;         // issue ring read at walk pointer
    logic acc;        // accumulate registered read data
    logic div_start;  // start division of field in div_sel
    logic [1:0] div_sel;
    logic finish;     // load result register
  } csqa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_more;  // more entries to read
    logic run_break;  // last read ended the run
    logic div_done;
  } csqa_sts_t;

  // value of a known code in 0.01 dB
  function automatic logic signed [15:0] lin_val(input logic [1:0] mode,
                                                 input logic [1:0] fld,
                                                 input logic [7:0] code);
    logic signed [15:0] c;
    logic signed [15:0] v;
    begin
      c = $signed({8'd0, code});
      v = '0;
      unique case (fld)
        2'd0: v = (c <<< 6) + (c <<< 5) + (c <<< 2) - 16'sd12000;
        2'd1: v = (c <<< 6) + (c <<< 5) + (c <<< 2)
                  - ((mode == ModeLte) ? 16'sd14000 : 16'sd12000);
        2'd2: v = (mode == ModeLte) ? ((c <<< 4) + (c <<< 2) - 16'sd2000)
                  : ((c <<< 5) + (c <<< 4) + (c <<< 1) - 16'sd3200);
        default: v = (c <<< 5) + (c <<< 4) + (c <<< 1) - 16'sd1950;
      endcase
      return v;
    end
  endfunction

endpackage

### hw/rtl/csqa_div.sv
// ----------------------------------------------------------------------------
// csqa_div
// serial signed divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module csqa_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [csqa_pkg::SumW-1:0]   num_i,
  input  logic [csqa_pkg::CntW-1:0]          den_i,
  output logic                               done_o,
  output logic signed [csqa_pkg::AvgW-1:0]   quo_o
);
  import csqa_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [CntW-1:0] den_q;
  logic            neg_q;
  logic [StepW-1:0] step_q;
  logic            busy_q, done_q;
  logic [SumW:0]   trial;
  logic [SumW-1:0] mag;

  assign mag = num_i[SumW-1] ? SumW'(-num_i) : num_i;
  assign trial = {rem_q, quo_q[SumW-1]} - {{(SumW + 1 - CntW){1'b0}}, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (!trial[SumW]) begin
      rem_d = trial[SumW-1:0];
      quo_d = {quo_q[SumW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[SumW-2:0], quo_q[SumW-1]};
      quo_d = {quo_q[SumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag;
      den_q <= den_i;
      neg_q <= num_i[SumW-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? AvgW'(-quo_q[AvgW-1:0]) : quo_q[AvgW-1:0];

endmodule

### hw/rtl/csqa_datapath.sv
// ----------------------------------------------------------------------------
// csqa_datapath
// sample ring, run walk, accumulators, divider and result register
// ----------------------------------------------------------------------------
module csqa_datapath #(
  parameter int unsigned MaxWindow = csqa_pkg::MaxWindowDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csqa_pkg::csqa_cmd_t           cmd_i,
  output csqa_pkg::csqa_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [csqa_pkg::WinW-1:0]     cfg_data_i,
  input  logic [1:0]                    in_mode_i,
  input  logic [31:0]                   in_codes_i,
  output logic                          res_emit_o,
  output logic [1:0]                    res_mode_o,
  output logic [31:0]                   res_number_o,
  output logic [csqa_pkg::WinW-1:0]     res_samples_o,
  output logic [4*csqa_pkg::AvgW-1:0]   res_avg_o,
  output logic [2:0]                    res_valid_o
);
  import csqa_pkg::*;

  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned FillW = $clog2(MaxWindow + 1);

  logic [1:0]  mem_mode [MaxWindow];
  logic [31:0] mem_code [MaxWindow];

  logic [FillW-1:0] win_q, fill_q, left_q;
  logic [IdxW-1:0]  wslot_q, rptr_q;
  logic [1:0]       run_mode_q, rd_mode_q;
  logic [31:0]      rd_code_q;
  logic [31:0]      rpt_q;
  logic signed [SumW-1:0] sum_q [4];
  logic [CntW-1:0]  cnt_q [4];
  logic             stop_q;
  logic [4*AvgW-1:0] avg_q;
  logic [FillW-1:0] cfg_w;
  logic             div_done;
  logic signed [AvgW-1:0] quo;
  logic [FillW-1:0] wplus;

  // clamp written window into 1..MaxWindow
  always_comb begin
    if (cfg_data_i == '0) cfg_w = FillW'(1);
    else if (32'(cfg_data_i) > MaxWindow) cfg_w = FillW'(MaxWindow);
    else cfg_w = FillW'(cfg_data_i);
  end

  assign wplus = FillW'(wslot_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= (32'(WinReset) > MaxWindow) ? FillW'(MaxWindow) : FillW'(WinReset);
      fill_q  <= '0;
      wslot_q <= '0;
      rpt_q   <= '0;
      stop_q  <= 1'b0;
      left_q  <= '0;
      rptr_q  <= '0;
      res_emit_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q   <= cfg_w;
        fill_q  <= '0;
        wslot_q <= '0;
      end
      if (cmd_i.store) begin
        wslot_q <= (wplus >= win_q) ? '0 : wslot_q + 1'b1;
        if (fill_q < win_q) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.clr_acc) begin
        stop_q <= 1'b0;
        left_q <= fill_q;
        rptr_q <= (wslot_q == '0) ? IdxW'(win_q - 1'b1) : wslot_q - 1'b1;
      end
      if (cmd_i.rd) begin
        left_q <= left_q - 1'b1;
        rptr_q <= (rptr_q == '0) ? IdxW'(win_q - 1'b1) : rptr_q - 1'b1;
      end
      if (cmd_i.acc && rd_mode_q != run_mode_q) stop_q <= 1'b1;
      if (cmd_i.finish) begin
        res_emit_o <= (cnt_q[0] != '0);
        if (cnt_q[0] != '0 && run_mode_q != ModeNone) rpt_q <= rpt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_mode[wslot_q] <= in_mode_i;
      mem_code[wslot_q] <= in_codes_i;
      run_mode_q <= in_mode_i;
    end
    if (cmd_i.rd) begin
      rd_mode_q <= mem_mode[rptr_q];
      rd_code_q <= mem_code[rptr_q];
    end
  end

  // accumulate one ring entry per accumulate command
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      for (int f = 0; f < 4; f++) begin
        sum_q[f] <= '0;
        cnt_q[f] <= '0;
      end
    end else if (cmd_i.acc && !stop_q && rd_mode_q == run_mode_q) begin
      if (run_mode_q == ModeNone) begin
        cnt_q[0] <= cnt_q[0] + 1'b1;
      end else begin
        for (int f = 0; f < 4; f++) begin
          if (rd_code_q[8*f +: 8] != CodeUnknown &&
              (f == 0 || (f < 3 && run_mode_q != ModeGsm) ||
               (f == 3 && run_mode_q == ModeLte))) begin
            sum_q[f] <= sum_q[f] + SumW'(lin_val(run_mode_q, 2'(f), rd_code_q[8*f +: 8]));
            cnt_q[f] <= cnt_q[f] + 1'b1;
          end
        end
      end
    end
  end

  csqa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_q[cmd_i.div_sel]),
    .den_i   (cnt_q[cmd_i.div_sel]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // capture quotient into the slot of the field being divided
  always_ff @(posedge clk_i) begin
    logic [1:0] sel_q;
    if (cmd_i.div_start) sel_q <= cmd_i.div_sel;
    if (cmd_i.clr_acc) avg_q <= '0;
    else if (div_done && cnt_q[sel_q] != '0 && run_mode_q != ModeNone)
      avg_q[AvgW*sel_q +: AvgW] <= quo;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_mode_o    <= run_mode_q;
      res_number_o  <= (run_mode_q != ModeNone) ? rpt_q + 1'b1 : rpt_q;
      res_samples_o <= WinW'(cnt_q[0]);
      res_avg_o     <= avg_q;
      res_valid_o   <= {cnt_q[3] != '0, cnt_q[2] != '0, cnt_q[1] != '0};
    end
  end

  assign sts_o.walk_more = (left_q != '0);
  assign sts_o.run_break = stop_q;
  assign sts_o.div_done  = div_done;

endmodule

### hw/rtl/csqa_ctrl.sv
// ----------------------------------------------------------------------------
// csqa_ctrl
// sequencer: store, walk the ring, divide four fields, hand off result
// ----------------------------------------------------------------------------
module csqa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 res_free_i,
  output csqa_pkg::csqa_cmd_t  cmd_o,
  input  csqa_pkg::csqa_sts_t  sts_i
);
  import csqa_pkg::*;

  `include "cell_signal_quality_averager_assert.svh"

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StClr   = 7'b0000010,
    StRead  = 7'b0000100,
    StAcc   = 7'b0001000,
    StDiv   = 7'b0010000,
    StWait  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] sel_q, sel_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.store = 1'b1;
        state_d = StClr;
      end
      StClr: begin
        cmd_o.clr_acc = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        if (sts_i.walk_more && !sts_i.run_break) begin
          cmd_o.rd = 1'b1;
          state_d = StAcc;
        end else begin
          sel_d = '0;
          state_d = StDiv;
        end
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d = StRead;
      end
      StDiv: begin
        cmd_o.div_start = 1'b1;
        state_d = StWait;
      end
      StWait: if (sts_i.div_done) begin
        if (sel_q == 2'd3) state_d = StOut;
        else begin
          sel_d = sel_q + 1'b1;
          state_d = StDiv;
        end
      end
      StOut: if (res_free_i) begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  `CSQA_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `CSQA_ASSERT_NEXT(a_store_clr, clk_i, rst_ni, cmd_o.store, cmd_o.clr_acc,
                    "store not followed by clear")
  `CSQA_ASSERT_NEXT(a_rd_acc, clk_i, rst_ni, cmd_o.rd, cmd_o.acc,
                    "read not followed by accumulate")

endmodule

### hw/rtl/cell_signal_quality_averager.sv
// ----------------------------------------------------------------------------
// cell_signal_quality_averager
// averages modem quality codes over the latest run of same-mode samples
// ----------------------------------------------------------------------------
// One sample is taken at a time. An item is stored, then the ring is walked
// one entry per read and accumulate step (up to window_size entries), then
// four serial divisions run; at a full window the divider takes the bulk of
// the time. A report leaves through a one-deep output register, so the
// next sample is taken while a report waits, and the block holds only when a
// second report is ready before the first was taken. Writing the window
// register empties the ring; there is no clearing pass.
module cell_signal_quality_averager #(
  parameter int unsigned MaxWindow = csqa_pkg::MaxWindowDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // radio_mode, code_a, code_b, code_c, code_d
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // report_mode, report_number, rssi_samples, avg_a..avg_d, valid_b..valid_d
  output logic [103:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [csqa_pkg::WinW-1:0] cfg_data_i
);
  import csqa_pkg::*;

  csqa_cmd_t cmd;
  csqa_sts_t sts;
  logic res_emit;
  logic [1:0] res_mode;
  logic [31:0] res_num;
  logic [WinW-1:0] res_smp;
  logic [4*AvgW-1:0] res_avg;
  logic [2:0] res_val;
  logic out_v_q, emit_q;

  assign cfg_ready_o = 1'b1;

  csqa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .res_free_i (!out_v_q || m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  csqa_datapath #(.MaxWindow(MaxWindow)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_mode_i     (s_axis_tdata[1:0]),
    .in_codes_i    (s_axis_tdata[33:2] ),
    .res_emit_o    (res_emit),
    .res_mode_o    (res_mode),
    .res_number_o  (res_num),
    .res_samples_o (res_smp),
    .res_avg_o     (res_avg),
    .res_valid_o   (res_val)
  );

  // datapath result register updates on finish; a pulse marks a new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      emit_q <= cmd.finish;
      if (emit_q && res_emit) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, res_val, res_avg, res_smp, res_num, res_mode};

endmodule

### test/cell_signal_quality_averager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cell_signal_quality_averager_tb
// drives radio quality samples, predicts the run averages in a local model of
// the ring and compares every report field by field under random back-pressure
// ----------------------------------------------------------------------------
module cell_signal_quality_averager_tb;
  import csqa_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 1500000;

  // first member lands in the highest bits
  typedef struct packed {
    logic        valid_d;
    logic        valid_c;
    logic        valid_b;
    logic [14:0] avg_d;
    logic [14:0] avg_c;
    logic [14:0] avg_b;
    logic [14:0] avg_a;
    logic [4:0]  samples;
    logic [31:0] number;
    logic [1:0]  mode;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [WinW-1:0] cfg_data_i = '0;

  // predictor state
  logic [1:0]  ring_mode [Depth];
  logic [31:0] ring_code [Depth];
  int unsigned wr_slot, filled, win, reports_done;

  report_t expected_reports[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;
  bit stall_long = 1'b0;

  cell_signal_quality_averager u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [14:0] mean15(int sum, int unsigned cnt);
    int v;
    v = (cnt != 0) ? sum / int'(cnt) : 0;
    return v[14:0];
  endfunction

  // an idle gap before each transfer so valid drops between transfers
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  // update the ring model with one sample and queue the report it causes
  task automatic predict_report(logic [1:0] mode, logic [7:0] ca, logic [7:0] cb,
                                logic [7:0] cc, logic [7:0] cd);
    int unsigned slot, idx, cnt[4];
    int sum[4];
    logic [31:0] c;
    logic [7:0] a, b, x, d;
    report_t r;
    cnt = '{0, 0, 0, 0};
    sum = '{0, 0, 0, 0};
    slot = wr_slot % win;
    ring_mode[slot] = mode;
    ring_code[slot] = {cd, cc, cb, ca};
    wr_slot = (slot + 1) % win;
    if (filled < win) filled++;
    for (int k = 0; k < filled; k++) begin
      idx = (wr_slot + win - 1 - k) % win;
      if (ring_mode[idx] != mode) break;
      c = ring_code[idx];
      {d, x, b, a} = c;
      if (mode == ModeNone) begin
        cnt[0]++;
        continue;
      end
      if (a != CodeUnknown) begin sum[0] += int'(a) * 100 - 12000; cnt[0]++; end
      if (mode == ModeLte) begin
        if (b != CodeUnknown) begin sum[1] += int'(b) * 100 - 14000; cnt[1]++; end
        if (x != CodeUnknown) begin sum[2] += int'(x) * 20 - 2000; cnt[2]++; end
        if (d != CodeUnknown) begin sum[3] += int'(d) * 50 - 1950; cnt[3]++; end
      end else if (mode == ModeWcdma) begin
        if (b != CodeUnknown) begin sum[1] += int'(b) * 100 - 12000; cnt[1]++; end
        if (x != CodeUnknown) begin sum[2] += int'(x) * 50 - 3200; cnt[2]++; end
      end
    end
    if (cnt[0] == 0) return;
    if (mode == ModeNone) begin
      r.avg_a = '0;
    end else begin
      reports_done++;
      r.avg_a = mean15(sum[0], cnt[0]);
    end
    r.mode = mode;
    r.number = reports_done;
    r.samples = cnt[0][4:0];
    r.avg_b = mean15(sum[1], cnt[1]);
    r.avg_c = mean15(sum[2], cnt[2]);
    r.avg_d = mean15(sum[3], cnt[3]);
    r.valid_b = cnt[1] != 0;
    r.valid_c = cnt[2] != 0;
    r.valid_d = cnt[3] != 0;
    expected_reports.push_back(r);
  endtask

  task automatic send_sample(logic [1:0] mode, logic [7:0] ca, logic [7:0] cb,
                             logic [7:0] cc, logic [7:0] cd);
    int unsigned g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, cd, cc, cb, ca, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_report(mode, ca, cb, cc, cd);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for the queue to drain, then for the block to finish a silent item
  task automatic drain();
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic set_window(logic [WinW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    win = (value == 0) ? 1 : (value > Depth) ? Depth : value;
    wr_slot = 0;
    filled = 0;
  endtask

  function automatic logic [7:0] rand_code();
    return ($urandom_range(0, 7) == 0) ? CodeUnknown : 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    send_sample(ModeLte, 8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(ModeLte, 8'd254, 8'd254, 8'd254, 8'd254);
    send_sample(ModeLte, 8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(ModeLte, 8'd255, 8'd10, 8'd20, 8'd30);
    send_sample(ModeWcdma, 8'd255, 8'd0, 8'd0, 8'd0);
    send_sample(ModeWcdma, 8'd60, 8'd255, 8'd64, 8'd77);
    send_sample(ModeWcdma, 8'd255, 8'd254, 8'd255, 8'd255);
    send_sample(ModeGsm, 8'd31, 8'd1, 8'd2, 8'd3);
    send_sample(ModeGsm, 8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(ModeNone, 8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(ModeNone, 8'd0, 8'd170, 8'd85, 8'd1);
    send_sample(ModeLte, 8'd170, 8'd85, 8'd170, 8'd85);
    send_sample(ModeLte, 8'd85, 8'd170, 8'd85, 8'd170);
  endtask

  task automatic test_window_extremes();
    set_window(5'd0);
    repeat (4) send_sample(ModeLte, rand_code(), rand_code(), rand_code(), rand_code());
    set_window(5'd31);
    repeat (20) send_sample(ModeWcdma, 8'($urandom_range(0, 254)), rand_code(),
                            rand_code(), rand_code());
    set_window(5'd16);
    repeat (18) send_sample(ModeNone, rand_code(), rand_code(), rand_code(), rand_code());
  endtask

  // random runs that may change mode; a few samples have every code unknown
  task automatic test_random(int unsigned items);
    logic [1:0] mode;
    int unsigned len, n;
    n = 0;
    while (n < items) begin
      mode = 2'($urandom_range(0, 3));
      len = $urandom_range(1, 20);
      for (int i = 0; i < len && n < items; i++, n++) begin
        if ($urandom_range(0, 9) == 0) mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 30) == 0)
          send_sample(mode, 8'd255, 8'd255, 8'd255, 8'd255);
        else
          send_sample(mode, rand_code(), rand_code(), rand_code(), rand_code());
      end
    end
  endtask

  task automatic test_backpressure();
    stall_long = 1'b1;
    repeat (12) send_sample(ModeLte, rand_code(), rand_code(), rand_code(), rand_code());
  endtask

  // receiver
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    int unsigned n;
    wait (stall_long);
    hold_off = 1'b1;
    n = 0;
    while (n < 2000) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    report_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[101:0];
      if (expected_reports.size() == 0) begin
        $error("unexpected report %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (got.mode != exp_r.mode) begin
          $error("report_mode exp %0d got %0d", exp_r.mode, got.mode); errors++; end
        if (got.number != exp_r.number) begin
          $error("report_number exp %0d got %0d", exp_r.number, got.number); errors++; end
        if (got.samples != exp_r.samples) begin
          $error("rssi_samples exp %0d got %0d", exp_r.samples, got.samples); errors++; end
        if (got.avg_a != exp_r.avg_a) begin
          $error("avg_a exp %0d got %0d", $signed(exp_r.avg_a), $signed(got.avg_a)); errors++; end
        if (got.avg_b != exp_r.avg_b) begin
          $error("avg_b exp %0d got %0d", $signed(exp_r.avg_b), $signed(got.avg_b)); errors++; end
        if (got.avg_c != exp_r.avg_c) begin
          $error("avg_c exp %0d got %0d", $signed(exp_r.avg_c), $signed(got.avg_c)); errors++; end
        if (got.avg_d != exp_r.avg_d) begin
          $error("avg_d exp %0d got %0d", $signed(exp_r.avg_d), $signed(got.avg_d)); errors++; end
        if (got.valid_b != exp_r.valid_b) begin
          $error("valid_b exp %0d got %0d", exp_r.valid_b, got.valid_b); errors++; end
        if (got.valid_c != exp_r.valid_c) begin
          $error("valid_c exp %0d got %0d", exp_r.valid_c, got.valid_c); errors++; end
        if (got.valid_d != exp_r.valid_d) begin
          $error("valid_d exp %0d got %0d", exp_r.valid_d, got.valid_d); errors++; end
      end
    end
  end

  initial begin
    win = WinReset;
    wr_slot = 0;
    filled = 0;
    reports_done = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_window_extremes();
    test_backpressure();
    set_window(5'd4);
    test_random(350);
    set_window(5'd1);
    test_random(150);
    set_window(5'd16);
    test_random(550);
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
